// ----- rtl/alert_controller_with_command_matcher_assert.svh -----
// Assertion macros for the alert controller with command matcher.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef ALERT_CONTROLLER_WITH_COMMAND_MATCHER_ASSERT_SVH
`define ALERT_CONTROLLER_WITH_COMMAND_MATCHER_ASSERT_SVH

// same-cycle implication, off during reset
`define ACM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define ACM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/acm_pkg.sv -----
// Shared types, constants and command tables of the alert controller.
// No dependencies.
`default_nettype none

package acm_pkg;

    localparam int ACM_LINE_CAPACITY = 128;
    localparam int ACM_QUEUE_DEPTH   = 2;
    localparam int ACM_CFG_IDX_W     = 3;
    localparam int ACM_CFG_DATA_W    = 16;

    localparam logic [ACM_CFG_IDX_W-1:0] CFG_ALERT_TIME    = 3'd0;
    localparam logic [ACM_CFG_IDX_W-1:0] CFG_COOLDOWN_TIME = 3'd1;
    localparam logic [ACM_CFG_IDX_W-1:0] CFG_HB_PERIOD     = 3'd2;
    localparam logic [ACM_CFG_IDX_W-1:0] CFG_DEBOUNCE      = 3'd3;
    localparam logic [ACM_CFG_IDX_W-1:0] CFG_ALERT_TOGGLE  = 3'd4;
    localparam logic [ACM_CFG_IDX_W-1:0] CFG_COOLDOWN_BLINK = 3'd5;

    localparam logic [15:0] RST_ALERT_TIME     = 16'd10000;
    localparam logic [15:0] RST_COOLDOWN_TIME  = 16'd5000;
    localparam logic [15:0] RST_HB_PERIOD      = 16'd3000;
    localparam logic [7:0]  RST_DEBOUNCE       = 8'd50;
    localparam logic [11:0] RST_ALERT_TOGGLE   = 12'd300;
    localparam logic [11:0] RST_COOLDOWN_BLINK = 12'd250;

    localparam int CAND_MATCH     = 0;
    localparam int CAND_HEARTBEAT = 1;
    localparam int CAND_PING      = 2;
    localparam int CAND_CLEAR     = 3;
    localparam int NUM_CAND       = 4;

    localparam logic [3:0] LEN_MATCH     = 4'd6;
    localparam logic [3:0] LEN_HEARTBEAT = 4'd9;
    localparam logic [3:0] LEN_PING      = 4'd4;
    localparam logic [3:0] LEN_CLEAR     = 4'd5;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_ALERT    = 2'd1,
        MODE_COOLDOWN = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        REPLY_NONE    = 2'd0,
        REPLY_ACK     = 2'd1,
        REPLY_PONG    = 2'd2,
        REPLY_UNKNOWN = 2'd3
    } t_reply;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_MATCH,
        CMD_HEARTBEAT,
        CMD_PING,
        CMD_CLEAR,
        CMD_UNKNOWN
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic button;
        t_cmd cmd;
    } t_event;

    typedef struct packed {
        t_mode  system_mode;
        logic   green_led;
        logic   blue_led;
        logic   red_led;
        logic   buzzer_on;
        t_reply host_reply;
        logic   radio_match;
        logic   radio_panic;
        logic   radio_heartbeat;
    } t_result;

    function automatic logic [7:0] cmd_char(input int cand, input logic [3:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (cand)
            CAND_MATCH: begin
                case (pos)
                    4'd0: c = "M";
                    4'd1: c = "A";
                    4'd2: c = "T";
                    4'd3: c = "C";
                    4'd4: c = "H";
                    4'd5: c = ":";
                    default: c = 8'h00;
                endcase
            end
            CAND_HEARTBEAT: begin
                case (pos)
                    4'd0: c = "H";
                    4'd1: c = "E";
                    4'd2: c = "A";
                    4'd3: c = "R";
                    4'd4: c = "T";
                    4'd5: c = "B";
                    4'd6: c = "E";
                    4'd7: c = "A";
                    4'd8: c = "T";
                    default: c = 8'h00;
                endcase
            end
            CAND_PING: begin
                case (pos)
                    4'd0: c = "P";
                    4'd1: c = "I";
                    4'd2: c = "N";
                    4'd3: c = "G";
                    default: c = 8'h00;
                endcase
            end
            default: begin
                case (pos)
                    4'd0: c = "C";
                    4'd1: c = "L";
                    4'd2: c = "E";
                    4'd3: c = "A";
                    4'd4: c = "R";
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic [3:0] cmd_len(input int cand);
        logic [3:0] l;
        case (cand)
            CAND_MATCH:     l = LEN_MATCH;
            CAND_HEARTBEAT: l = LEN_HEARTBEAT;
            CAND_PING:      l = LEN_PING;
            default:        l = LEN_CLEAR;
        endcase
        return l;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/acm_front.sv -----
// Front end: accepts items, runs the host line matcher, and classifies
// each item into one event. Depends on acm_pkg.
`default_nettype none

module acm_front import acm_pkg::*; #(
    parameter int LINE_CAPACITY = ACM_LINE_CAPACITY
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic       i_mode,
    input  wire logic [7:0] i_host_byte,
    input  wire logic       i_button_low,
    output t_event          o_event
);

    localparam int LW = $clog2(LINE_CAPACITY);

    logic [LW-1:0]       r_len, n_len;
    logic [NUM_CAND-1:0] r_cand, n_cand;
    logic                is_eol;

    assign is_eol = (i_host_byte == CHAR_LF) || (i_host_byte == CHAR_CR);

    always_comb begin
        n_len           = r_len;
        n_cand          = r_cand;
        o_event.is_tick = i_mode;
        o_event.button  = i_button_low;
        o_event.cmd     = CMD_NONE;
        if (!i_mode) begin
            if (is_eol) begin
                if (r_len != '0) begin
                    if (r_cand[CAND_MATCH] && r_len >= LW'(LEN_MATCH)) begin
                        o_event.cmd = CMD_MATCH;
                    end else if (r_cand[CAND_HEARTBEAT] && r_len == LW'(LEN_HEARTBEAT)) begin
                        o_event.cmd = CMD_HEARTBEAT;
                    end else if (r_cand[CAND_PING] && r_len == LW'(LEN_PING)) begin
                        o_event.cmd = CMD_PING;
                    end else if (r_cand[CAND_CLEAR] && r_len == LW'(LEN_CLEAR)) begin
                        o_event.cmd = CMD_CLEAR;
                    end else begin
                        o_event.cmd = CMD_UNKNOWN;
                    end
                    n_len  = '0;
                    n_cand = '1;
                end
            end else if (r_len < LW'(LINE_CAPACITY - 1)) begin
                for (int k = 0; k < NUM_CAND; k++) begin
                    if (r_len < LW'(cmd_len(k))) begin
                        if (cmd_char(k, r_len[3:0]) != i_host_byte) begin
                            n_cand[k] = 1'b0;
                        end
                    end else if (k != CAND_MATCH) begin
                        n_cand[k] = 1'b0;
                    end
                end
                n_len = r_len + LW'(1);
            end else begin
                n_len  = '0;
                n_cand = '1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_cand <= '1;
        end else if (i_take) begin
            r_len  <= n_len;
            r_cand <= n_cand;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/acm_queue.sv -----
// Short event queue between the front end and the controller.
// Depends on acm_pkg and the assertion macro header.
`default_nettype none
`include "alert_controller_with_command_matcher_assert.svh"

module acm_queue import acm_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_event i_data,
    output logic        o_not_full,
    input  wire logic   i_pop,
    output logic        o_not_empty,
    output t_event      o_data
);

    localparam int DEPTH = ACM_QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    t_event         r_mem [DEPTH];
    logic [PW-1:0]  r_wptr, r_rptr;
    logic [CW-1:0]  r_count;

    assign o_not_full  = (r_count != CW'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_data      = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `ACM_ASSERT_IMP(a_no_push_full, i_push, r_count != CW'(DEPTH), "push into full queue")
    `ACM_ASSERT_IMP(a_no_pop_empty, i_pop, r_count != '0, "pop from empty queue")
    `ACM_ASSERT_NXT(a_push_grows, i_push && !i_pop, r_count == $past(r_count) + CW'(1), "count lost")

endmodule

`default_nettype wire

// ----- rtl/acm_back.sv -----
// Controller back end: mode machine, timers, debounce, blink phases and
// the registered result stage. Depends on acm_pkg and the assertion macros.
`default_nettype none
`include "alert_controller_with_command_matcher_assert.svh"

module acm_back import acm_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [ACM_CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ACM_CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                      i_ev_valid,
    input  wire t_event                    i_ev,
    output logic                           o_ev_pop,
    output logic                           o_res_valid,
    input  wire logic                      i_res_ready,
    output t_result                        o_res
);

    logic [15:0] r_cfg_alert, r_cfg_cool, r_cfg_hb;
    logic [7:0]  r_cfg_deb;
    logic [11:0] r_cfg_toggle, r_cfg_blink;

    t_mode       r_mode, n_mode;
    logic [15:0] r_time, n_time, r_hb, n_hb;
    logic        r_btn_prev, n_btn_prev, r_db_act, n_db_act;
    logic [7:0]  r_db_cnt, n_db_cnt;
    logic [11:0] r_apc, n_apc, r_bpc, n_bpc;
    logic        r_aph, n_aph, r_bph, n_bph;

    t_reply      n_reply;
    logic        n_match, n_panic, n_hbf;
    t_result     n_res, r_res;
    logic        r_res_valid;

    assign o_ev_pop    = i_ev_valid && (!r_res_valid || i_res_ready);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_alert  <= RST_ALERT_TIME;
            r_cfg_cool   <= RST_COOLDOWN_TIME;
            r_cfg_hb     <= RST_HB_PERIOD;
            r_cfg_deb    <= RST_DEBOUNCE;
            r_cfg_toggle <= RST_ALERT_TOGGLE;
            r_cfg_blink  <= RST_COOLDOWN_BLINK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ALERT_TIME:     r_cfg_alert  <= i_cfg_data;
                CFG_COOLDOWN_TIME:  r_cfg_cool   <= i_cfg_data;
                CFG_HB_PERIOD:      r_cfg_hb     <= i_cfg_data;
                CFG_DEBOUNCE:       r_cfg_deb    <= i_cfg_data[7:0];
                CFG_ALERT_TOGGLE:   r_cfg_toggle <= i_cfg_data[11:0];
                CFG_COOLDOWN_BLINK: r_cfg_blink  <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_mode     = r_mode;
        n_time     = r_time;
        n_hb       = r_hb;
        n_btn_prev = r_btn_prev;
        n_db_act   = r_db_act;
        n_db_cnt   = r_db_cnt;
        n_apc      = r_apc;
        n_aph      = r_aph;
        n_bpc      = r_bpc;
        n_bph      = r_bph;
        n_reply    = REPLY_NONE;
        n_match    = 1'b0;
        n_panic    = 1'b0;
        n_hbf      = 1'b0;
        if (i_ev.is_tick) begin
            n_time = (r_time == 16'hFFFF) ? r_time : r_time + 16'd1;
            n_hb   = (r_hb == 16'hFFFF) ? r_hb : r_hb + 16'd1;
            n_apc  = r_apc + 12'd1;
            if (n_apc >= r_cfg_toggle) begin
                n_apc = '0;
                n_aph = ~r_aph;
            end
            n_bpc = r_bpc + 12'd1;
            if (n_bpc >= r_cfg_blink) begin
                n_bpc = '0;
                n_bph = ~r_bph;
            end
            if (r_db_act) begin
                n_db_cnt = r_db_cnt + 8'd1;
                if (n_db_cnt >= r_cfg_deb) begin
                    n_db_act = 1'b0;
                    if (i_ev.button) begin
                        n_panic = 1'b1;
                        n_mode  = MODE_ALERT;
                        n_time  = '0;
                    end
                end
            end else if (i_ev.button && !r_btn_prev) begin
                n_db_act = 1'b1;
                n_db_cnt = '0;
            end
            n_btn_prev = i_ev.button;
            if (n_mode == MODE_ALERT && n_time > r_cfg_alert) begin
                n_mode = MODE_COOLDOWN;
                n_time = '0;
            end else if (n_mode == MODE_COOLDOWN && n_time > r_cfg_cool) begin
                n_mode = MODE_IDLE;
                n_time = '0;
            end
            if (n_hb > r_cfg_hb) begin
                n_hb  = '0;
                n_hbf = 1'b1;
            end
        end else begin
            unique case (i_ev.cmd)
                CMD_MATCH: begin
                    n_reply = REPLY_ACK;
                    n_match = 1'b1;
                    n_mode  = MODE_ALERT;
                    n_time  = '0;
                end
                CMD_HEARTBEAT: n_reply = REPLY_ACK;
                CMD_PING:      n_reply = REPLY_PONG;
                CMD_CLEAR: begin
                    n_reply = REPLY_ACK;
                    if (r_mode == MODE_ALERT) begin
                        n_mode = MODE_COOLDOWN;
                        n_time = '0;
                    end
                end
                CMD_UNKNOWN:   n_reply = REPLY_UNKNOWN;
                default:       n_reply = REPLY_NONE;
            endcase
        end
    end

    // outputs
    always_comb begin
        n_res.system_mode     = n_mode;
        n_res.green_led       = 1'b0;
        n_res.blue_led        = 1'b0;
        n_res.red_led         = 1'b0;
        n_res.buzzer_on       = 1'b0;
        n_res.host_reply      = n_reply;
        n_res.radio_match     = n_match;
        n_res.radio_panic     = n_panic;
        n_res.radio_heartbeat = n_hbf;
        unique case (n_mode)
            MODE_IDLE:     n_res.green_led = 1'b1;
            MODE_COOLDOWN: n_res.green_led = n_bph;
            MODE_ALERT: begin
                n_res.blue_led  = n_aph;
                n_res.red_led   = ~n_aph;
                n_res.buzzer_on = n_aph;
            end
            default: n_res.green_led = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_time      <= '0;
            r_hb        <= '0;
            r_btn_prev  <= 1'b0;
            r_db_act    <= 1'b0;
            r_db_cnt    <= '0;
            r_apc       <= '0;
            r_aph       <= 1'b0;
            r_bpc       <= '0;
            r_bph       <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (o_ev_pop) begin
                r_mode     <= n_mode;
                r_time     <= n_time;
                r_hb       <= n_hb;
                r_btn_prev <= n_btn_prev;
                r_db_act   <= n_db_act;
                r_db_cnt   <= n_db_cnt;
                r_apc      <= n_apc;
                r_aph      <= n_aph;
                r_bpc      <= n_bpc;
                r_bph      <= n_bph;
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ev_pop) begin
            r_res <= n_res;
        end
    end

    `ACM_ASSERT_IMP(a_match_alert, r_res_valid && r_res.radio_match, r_res.system_mode == MODE_ALERT, "match without alert")
    `ACM_ASSERT_IMP(a_panic_alert, r_res_valid && r_res.radio_panic, r_res.system_mode == MODE_ALERT, "panic without alert")
    `ACM_ASSERT_NXT(a_match_timer, o_ev_pop && !i_ev.is_tick && i_ev.cmd == CMD_MATCH, r_time == '0, "alert timer not restarted")

endmodule

`default_nettype wire

// ----- rtl/alert_controller_with_command_matcher.sv -----
// Alert controller with host command matcher, top level.
// Depends on acm_pkg, acm_front, acm_queue and acm_back.
//
// Takes one item per cycle while the queue has room, either a host byte or a
// millisecond tick, and gives one result per item: the front end classifies
// the item and writes a two-entry event queue, and the controller pops one
// event a cycle into its output register while that is empty or being taken.
// Input and output stall independently; one item per clock is sustained while
// results are taken. Configuration writes take effect at the next edge.
`default_nettype none

module alert_controller_with_command_matcher import acm_pkg::*; #(
    parameter int LINE_CAPACITY = ACM_LINE_CAPACITY
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [ACM_CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ACM_CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic                      i_mode,
    input  wire logic [7:0]                i_host_byte,
    input  wire logic                      i_button_low,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [1:0]                     o_system_mode,
    output logic                           o_green_led,
    output logic                           o_blue_led,
    output logic                           o_red_led,
    output logic                           o_buzzer_on,
    output logic [1:0]                     o_host_reply,
    output logic                           o_radio_match,
    output logic                           o_radio_panic,
    output logic                           o_radio_heartbeat
);

    logic    take, q_not_full, q_not_empty, q_pop;
    t_event  fr_event, q_event;
    t_result res;

    assign o_ready = q_not_full;
    assign take    = i_valid && q_not_full;

    acm_front #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_mode       (i_mode),
        .i_host_byte  (i_host_byte),
        .i_button_low (i_button_low),
        .o_event      (fr_event)
    );

    acm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (take),
        .i_data      (fr_event),
        .o_not_full  (q_not_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_data      (q_event)
    );

    acm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_ev_valid  (q_not_empty),
        .i_ev        (q_event),
        .o_ev_pop    (q_pop),
        .o_res_valid (o_valid),
        .i_res_ready (i_ready),
        .o_res       (res)
    );

    assign o_system_mode     = res.system_mode;
    assign o_green_led       = res.green_led;
    assign o_blue_led        = res.blue_led;
    assign o_red_led         = res.red_led;
    assign o_buzzer_on       = res.buzzer_on;
    assign o_host_reply      = res.host_reply;
    assign o_radio_match     = res.radio_match;
    assign o_radio_panic     = res.radio_panic;
    assign o_radio_heartbeat = res.radio_heartbeat;

endmodule

`default_nettype wire
